>>> rtl/dls_pkg.sv
// Shared types and constants of the dense layer SGD core.
`default_nettype none
package dls_pkg;

	// Width of element counts (holds up to 511).
	localparam int CNT_W = 9;
	// Fixed fraction width of the learning-rate step.
	localparam int LR_BITS = 16;

	// Request type codes.
	localparam logic [1:0] REQ_LOAD_W = 2'd0;
	localparam logic [1:0] REQ_LOAD_B = 2'd1;
	localparam logic [1:0] REQ_FWD    = 2'd2;
	localparam logic [1:0] REQ_BWD    = 2'd3;

	// Result kinds.
	localparam logic RK_FWD  = 1'b0;
	localparam logic RK_GRAD = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] CFG_IN_COUNT  = 2'd0;
	localparam logic [1:0] CFG_OUT_COUNT = 2'd1;
	localparam logic [1:0] CFG_LR        = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [5:0]         row_index;
		logic [5:0]         col_index;
		logic signed [31:0] data_value;
	} req_t;

	typedef struct packed {
		logic               result_kind;
		logic [5:0]         result_index;
		logic signed [31:0] result_value;
		logic               is_last;
	} rsp_t;

	// Controls of the shared multiply-accumulate unit.
	typedef struct packed {
		logic mul_en;
		logic sub;
		logic lr_shift;
	} mac_ctl_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_F_RD,
		ST_F_MUL,
		ST_F_ACC,
		ST_B_RD,
		ST_B_M1,
		ST_B_M2,
		ST_B_M3,
		ST_B_M4,
		ST_B_WR,
		ST_B_ZERO,
		ST_BB_RD,
		ST_BB_MUL,
		ST_BB_WR,
		ST_E_RD,
		ST_E_OUT
	} st_t;

endpackage
`default_nettype wire

>>> rtl/dls_if.sv
// Handshake channel interfaces: request, result and configuration write.
`default_nettype none
interface dls_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [5:0]         row_index;
	logic [5:0]         col_index;
	logic signed [31:0] data_value;
	modport source (output valid, req_type, row_index, col_index, data_value, input ready);
	modport sink (input valid, req_type, row_index, col_index, data_value, output ready);
endinterface

interface dls_rsp_if;
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic [5:0]         result_index;
	logic signed [31:0] result_value;
	logic               is_last;
	modport source (output valid, result_kind, result_index, result_value, is_last,
		input ready);
	modport sink (input valid, result_kind, result_index, result_value, is_last,
		output ready);
endinterface

interface dls_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/dls_mac.sv
// Shared multiply unit with registered product, floor shift and saturating add/subtract.
`default_nettype none
module dls_mac #(
	parameter int FRAC_BITS = 16
) (
	input  wire                     clk,
	input  dls_pkg::mac_ctl_t       ctl,
	input  wire logic signed [32:0] op_a,
	input  wire logic signed [32:0] op_b,
	input  wire logic signed [31:0] addend,
	output logic signed [31:0]      sum
);
	import dls_pkg::*;

	localparam logic signed [66:0] SAT_MAX = 67'sd2147483647;
	localparam logic signed [66:0] SAT_MIN = -67'sd2147483648;

	logic signed [65:0] prod_q;
	logic signed [65:0] shifted;
	logic signed [66:0] total;

	// Product register
	always_ff @(posedge clk) begin
		if (ctl.mul_en) prod_q <= op_a * op_b;
	end

	// Floor shift, then add or subtract with saturation to 32 bits
	always_comb begin
		shifted = ctl.lr_shift ? (prod_q >>> LR_BITS) : (prod_q >>> FRAC_BITS);
		total = ctl.sub ? (67'(addend) - 67'(shifted)) : (67'(addend) + 67'(shifted));
		if (total > SAT_MAX) sum = 32'sh7FFF_FFFF;
		else if (total < SAT_MIN) sum = 32'sh8000_0000;
		else sum = total[31:0];
	end

endmodule
`default_nettype wire

>>> rtl/dls_ctrl.sv
// Sequencer with weight, bias and vector memories driving the shared MAC unit.
`default_nettype none
module dls_ctrl #(
	parameter int MAX_INPUTS  = 64,
	parameter int MAX_OUTPUTS = 64,
	parameter int FRAC_BITS   = 16
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_ready,
	input  dls_pkg::req_t    req,
	input  wire logic [6:0]  in_count,
	input  wire logic [6:0]  out_count,
	input  wire logic [15:0] step_size,
	output logic             out_valid,
	input  wire              out_ready,
	output dls_pkg::rsp_t    out_item
);
	import dls_pkg::*;

	localparam int NW = MAX_INPUTS * MAX_OUTPUTS;
	localparam int AW = (NW > 1) ? $clog2(NW) : 1;
	localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int OW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

	// Memories
	logic signed [31:0] wmem [NW];
	logic signed [31:0] bmem [MAX_OUTPUTS];
	logic signed [31:0] xmem [MAX_INPUTS];
	logic signed [31:0] smem [MAX_OUTPUTS];
	logic signed [31:0] gmem [MAX_INPUTS];

	st_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt_nxt;
	logic [AW-1:0]    clr_q;
	logic signed [31:0] data_q, gw_q;
	logic [5:0]       idx_q;
	logic             first_q, kind_q;
	logic             load_item;

	logic [CNT_W-1:0] ni, no, emit_len;
	logic             accept;

	logic               w_we, b_we, x_we, s_we, g_we;
	logic [AW-1:0]      w_addr;
	logic [OW-1:0]      b_addr, s_addr;
	logic [IW-1:0]      x_addr, g_addr;
	logic signed [31:0] w_wdata, b_wdata, g_wdata;
	logic signed [31:0] w_rd_q, b_rd_q, x_rd_q, s_rd_q, g_rd_q;

	mac_ctl_t           mac_ctl;
	logic signed [32:0] op_a, op_b;
	logic signed [31:0] addend, mac_sum;
	logic signed [32:0] lr_op;

	dls_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk    (clk),
		.ctl    (mac_ctl),
		.op_a   (op_a),
		.op_b   (op_b),
		.addend (addend),
		.sum    (mac_sum)
	);

	// Effective sizes: zero acts as one, clamp to the maximum
	always_comb begin
		if (in_count == 7'd0) ni = CNT_W'(1);
		else if (CNT_W'(in_count) > CNT_W'(MAX_INPUTS)) ni = CNT_W'(MAX_INPUTS);
		else ni = CNT_W'(in_count);
		if (out_count == 7'd0) no = CNT_W'(1);
		else if (CNT_W'(out_count) > CNT_W'(MAX_OUTPUTS)) no = CNT_W'(MAX_OUTPUTS);
		else no = CNT_W'(out_count);
	end

	assign accept   = req_valid && req_ready;
	assign cnt_nxt  = cnt_q + CNT_W'(1);
	assign lr_op    = {17'd0, step_size};
	assign emit_len = kind_q ? ni : no;

	// Memory ports
	always_ff @(posedge clk) begin
		if (w_we) wmem[w_addr] <= w_wdata;
		w_rd_q <= wmem[w_addr];
	end
	always_ff @(posedge clk) begin
		if (b_we) bmem[b_addr] <= b_wdata;
		b_rd_q <= bmem[b_addr];
	end
	always_ff @(posedge clk) begin
		if (x_we) xmem[x_addr] <= req.data_value;
		x_rd_q <= xmem[x_addr];
	end
	always_ff @(posedge clk) begin
		if (s_we) smem[s_addr] <= mac_sum;
		s_rd_q <= smem[s_addr];
	end
	always_ff @(posedge clk) begin
		if (g_we) gmem[g_addr] <= g_wdata;
		g_rd_q <= gmem[g_addr];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
		end
	end

	// Item payload registers
	assign load_item = accept && (req.req_type == REQ_FWD || req.req_type == REQ_BWD);
	always_ff @(posedge clk) begin
		if (load_item) begin
			data_q  <= req.data_value;
			idx_q   <= (req.req_type == REQ_FWD) ? req.col_index : req.row_index;
			first_q <= (req.req_type == REQ_FWD) ? (req.col_index == 6'd0)
				: (req.row_index == 6'd0);
			kind_q  <= (req.req_type == REQ_FWD) ? RK_FWD : RK_GRAD;
		end
		if (state_q == ST_B_M3) gw_q <= mac_sum;
	end

	// Next state, memory controls and MAC operands
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		req_ready = 1'b0;
		out_valid = 1'b0;
		w_we = 1'b0; b_we = 1'b0; x_we = 1'b0; s_we = 1'b0; g_we = 1'b0;
		w_addr  = AW'(int'(cnt_q) * MAX_INPUTS + int'(idx_q));
		b_addr  = cnt_q[OW-1:0];
		s_addr  = cnt_q[OW-1:0];
		x_addr  = cnt_q[IW-1:0];
		g_addr  = cnt_q[IW-1:0];
		w_wdata = mac_sum;
		b_wdata = mac_sum;
		g_wdata = mac_sum;
		mac_ctl = '0;
		op_a    = 33'(data_q);
		op_b    = 33'(w_rd_q);
		addend  = '0;
		out_item.result_kind  = kind_q;
		out_item.result_index = 6'(cnt_q);
		out_item.result_value = kind_q ? g_rd_q : s_rd_q;
		out_item.is_last      = (cnt_nxt == emit_len);

		case (state_q)
			ST_CLEAR: begin
				w_addr  = clr_q;
				b_addr  = clr_q[OW-1:0];
				w_wdata = '0;
				b_wdata = '0;
				w_we    = 1'b1;
				b_we    = (int'(clr_q) < MAX_OUTPUTS);
				if (int'(clr_q) == NW - 1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				w_addr  = AW'(int'(req.row_index) * MAX_INPUTS + int'(req.col_index));
				b_addr  = OW'(req.row_index);
				x_addr  = IW'(req.col_index);
				w_wdata = req.data_value;
				b_wdata = req.data_value;
				cnt_d   = '0;
				if (accept) begin
					case (req.req_type)
						REQ_LOAD_W: w_we = (int'(req.row_index) < MAX_OUTPUTS)
							&& (int'(req.col_index) < MAX_INPUTS);
						REQ_LOAD_B: b_we = (int'(req.row_index) < MAX_OUTPUTS);
						REQ_FWD: begin
							if (CNT_W'(req.col_index) < ni) begin
								x_we    = 1'b1;
								state_d = ST_F_RD;
							end
						end
						REQ_BWD: begin
							if (CNT_W'(req.row_index) < no) state_d = ST_B_RD;
						end
						default: ;
					endcase
				end
			end
			// Forward: per neuron, read, multiply, then accumulate
			ST_F_RD: state_d = ST_F_MUL;
			ST_F_MUL: begin
				mac_ctl.mul_en = 1'b1;
				state_d = ST_F_ACC;
			end
			ST_F_ACC: begin
				addend = first_q ? b_rd_q : s_rd_q;
				s_we   = 1'b1;
				cnt_d  = cnt_nxt;
				if (cnt_nxt == no) begin
					cnt_d   = '0;
					state_d = (CNT_W'(idx_q) + CNT_W'(1) == ni) ? ST_E_RD : ST_IDLE;
				end else begin
					state_d = ST_F_RD;
				end
			end
			// Backward: each input column passes through ST_B_RD, ST_B_M1 to ST_B_M4 and ST_B_WR
			ST_B_RD: begin
				w_addr  = AW'(int'(idx_q) * MAX_INPUTS + int'(cnt_q));
				state_d = ST_B_M1;
			end
			ST_B_M1: begin
				w_addr = AW'(int'(idx_q) * MAX_INPUTS + int'(cnt_q));
				mac_ctl.mul_en = 1'b1;
				op_a = 33'(w_rd_q);
				op_b = 33'(data_q);
				state_d = ST_B_M2;
			end
			ST_B_M2: begin
				w_addr = AW'(int'(idx_q) * MAX_INPUTS + int'(cnt_q));
				addend = first_q ? 32'sd0 : g_rd_q;
				g_we   = 1'b1;
				mac_ctl.mul_en = 1'b1;
				op_a = 33'(x_rd_q);
				op_b = 33'(data_q);
				state_d = ST_B_M3;
			end
			ST_B_M3: begin
				w_addr  = AW'(int'(idx_q) * MAX_INPUTS + int'(cnt_q));
				state_d = ST_B_M4;
			end
			ST_B_M4: begin
				w_addr = AW'(int'(idx_q) * MAX_INPUTS + int'(cnt_q));
				mac_ctl.mul_en = 1'b1;
				op_a = lr_op;
				op_b = 33'(gw_q);
				state_d = ST_B_WR;
			end
			ST_B_WR: begin
				w_addr = AW'(int'(idx_q) * MAX_INPUTS + int'(cnt_q));
				mac_ctl.sub      = 1'b1;
				mac_ctl.lr_shift = 1'b1;
				addend = w_rd_q;
				w_we   = 1'b1;
				cnt_d  = cnt_nxt;
				if (cnt_nxt < ni) state_d = ST_B_RD;
				else if (first_q && cnt_nxt < CNT_W'(MAX_INPUTS)) state_d = ST_B_ZERO;
				else state_d = ST_BB_RD;
			end
			// First gradient element: clear the rest of the input gradients
			ST_B_ZERO: begin
				g_wdata = '0;
				g_we    = 1'b1;
				cnt_d   = cnt_nxt;
				if (cnt_nxt == CNT_W'(MAX_INPUTS)) state_d = ST_BB_RD;
			end
			// Bias update
			ST_BB_RD: begin
				b_addr  = OW'(idx_q);
				state_d = ST_BB_MUL;
			end
			ST_BB_MUL: begin
				b_addr = OW'(idx_q);
				mac_ctl.mul_en = 1'b1;
				op_a = lr_op;
				op_b = 33'(data_q);
				state_d = ST_BB_WR;
			end
			ST_BB_WR: begin
				b_addr = OW'(idx_q);
				mac_ctl.sub      = 1'b1;
				mac_ctl.lr_shift = 1'b1;
				addend = b_rd_q;
				b_we   = 1'b1;
				cnt_d  = '0;
				state_d = (CNT_W'(idx_q) + CNT_W'(1) == no) ? ST_E_RD : ST_IDLE;
			end
			// Emission: read one element, then offer it
			ST_E_RD: state_d = ST_E_OUT;
			ST_E_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (out_item.is_last) begin
						cnt_d   = '0;
						state_d = ST_IDLE;
					end else begin
						cnt_d   = cnt_nxt;
						state_d = ST_E_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cnt_q < emit_len))
		else $error("emission index beyond vector length");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
		else $error("offered result changed before it was taken");
	a_fwd_product: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_F_ACC) |-> $past(mac_ctl.mul_en))
		else $error("accumulate without a fresh product");
	a_weight_write: assert property (@(posedge clk) disable iff (!arst_n)
		w_we |-> (state_q == ST_CLEAR || state_q == ST_IDLE || state_q == ST_B_WR))
		else $error("weight write outside load, clear or update");

endmodule
`default_nettype wire

>>> rtl/dense_layer_sgd_core.sv
// Top level: fully connected layer with on-line SGD training in fixed point.
// Channels: req (sink) takes load, forward and backward items; rsp (source) returns
// forward outputs and propagated input gradients, each vector closed by is_last;
// cfg (sink, always ready) writes in_count, out_count and the step size by index.
// After reset the weight and bias memories are swept to zero, one weight a cycle,
// over all MAX_INPUTS*MAX_OUTPUTS weights (4096 by default); req stays low meanwhile.
// With ni and no the effective input and output counts: a weight or bias load is
// taken and written in the idle state. A forward element updates the no sums in turn;
// the last one is followed by emission of the no outputs. A backward element updates
// the ni gradients and the ni weights of its row in turn, on element 0 also clears
// the rest of the gradient memory, then updates its bias; the last one is followed by
// the emission of the ni gradients. Work is serialised by the single shared multiplier
// and the single port on each memory. Requests are taken one at a time; req.ready
// is high only between items. Results pass through one output register: a stalled
// rsp holds the current result and halts emission until it is taken.
`default_nettype none
module dense_layer_sgd_core #(
	parameter int MAX_INPUTS  = 64,
	parameter int MAX_OUTPUTS = 64,
	parameter int FRAC_BITS   = 16
) (
	input wire        clk,
	input wire        arst_n,
	dls_req_if.sink   req,
	dls_rsp_if.source rsp,
	dls_cfg_if.sink   cfg
);
	import dls_pkg::*;

	logic [6:0]  in_count_q, out_count_q;
	logic [15:0] lr_q;
	req_t        req_item;
	rsp_t        core_item, rsp_q;
	logic        core_valid, core_ready, rsp_valid_q;

	// Configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_count_q  <= 7'd2;
			out_count_q <= 7'd4;
			lr_q        <= 16'd655;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_IN_COUNT:  in_count_q  <= cfg.data[6:0];
				CFG_OUT_COUNT: out_count_q <= cfg.data[6:0];
				CFG_LR:        lr_q        <= cfg.data;
				default: ;
			endcase
		end
	end

	assign req_item.req_type   = req.req_type;
	assign req_item.row_index  = req.row_index;
	assign req_item.col_index  = req.col_index;
	assign req_item.data_value = req.data_value;

	dls_ctrl #(
		.MAX_INPUTS  (MAX_INPUTS),
		.MAX_OUTPUTS (MAX_OUTPUTS),
		.FRAC_BITS   (FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req       (req_item),
		.in_count  (in_count_q),
		.out_count (out_count_q),
		.step_size (lr_q),
		.out_valid (core_valid),
		.out_ready (core_ready),
		.out_item  (core_item)
	);

	// Output register
	assign core_ready = !rsp_valid_q || rsp.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid_q <= 1'b0;
		else if (core_ready) rsp_valid_q <= core_valid;
	end
	always_ff @(posedge clk) begin
		if (core_ready && core_valid) rsp_q <= core_item;
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_kind  = rsp_q.result_kind;
	assign rsp.result_index = rsp_q.result_index;
	assign rsp.result_value = rsp_q.result_value;
	assign rsp.is_last      = rsp_q.is_last;

endmodule
`default_nettype wire

>>> sim/dense_layer_sgd_core_tb.sv
// Testbench of the dense layer SGD core: directed table, then random streams vs. a predictor.
`default_nettype none
module dense_layer_sgd_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dls_pkg::*;

	localparam int N_IN   = 64;
	localparam int N_OUT  = 64;
	localparam int FRAC   = 16;
	localparam int SETTLE = 600;      // cycles covering the slowest item with no result
	localparam int LIMIT  = 4000000;  // cycle limit of the whole run
	localparam int HOLD   = 3000;     // long receiver hold-off
	localparam logic [1:0] CFG_SPARE = 2'd3;  // unused register index

	logic clk;
	logic arst_n;
	dls_req_if req_ch ();
	dls_rsp_if rsp_ch ();
	dls_cfg_if cfg_ch ();

	dense_layer_sgd_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// layer state as the block should hold it
	logic signed [31:0] weights [0:N_OUT*N_IN-1];
	logic signed [31:0] biases [0:N_OUT-1];
	logic signed [31:0] kept_x [0:N_IN-1];
	logic signed [31:0] sums [0:N_OUT-1];
	logic signed [31:0] grads [0:N_IN-1];
	bit kept_ok [0:N_IN-1];
	bit sum_ok [0:N_OUT-1];
	bit grad_ok;
	bit [6:0] in_reg;
	bit [6:0] out_reg;
	bit [15:0] lr_reg;

	rsp_t layer_results [$];   // results awaiting the output port
	rsp_t new_results [$];     // results of the item just taken
	int fails;
	int cycles;
	int hold_req;
	int burst_left;

	typedef struct {
		req_t item;
		bit   known;
		rsp_t first;
	} dir_row_t;
	dir_row_t script [$];

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic signed [31:0] sat32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic int eff(bit [6:0] r, int top);
		if (r == 0) return 1;
		if (r > top) return top;
		return r;
	endfunction

	// an item that would read never-written accumulators or inputs
	function automatic bit reads_unwritten(req_t it);
		int ni;
		int no;
		ni = eff(in_reg, N_IN);
		no = eff(out_reg, N_OUT);
		if (it.req_type == REQ_FWD && it.col_index < ni && it.col_index != 0)
			for (int i = 0; i < no; i++) if (!sum_ok[i]) return 1;
		if (it.req_type == REQ_BWD && it.row_index < no) begin
			if (it.row_index != 0 && !grad_ok) return 1;
			for (int j = 0; j < ni; j++) if (!kept_ok[j]) return 1;
		end
		return 0;
	endfunction

	// apply one taken item; fills new_results, returns 0 if the item is ignored
	function automatic bit layer_predict(req_t it);
		int ni;
		int no;
		longint lr;
		longint d;
		longint p;
		logic signed [31:0] gw;
		logic signed [31:0] w;
		rsp_t r;
		ni = eff(in_reg, N_IN);
		no = eff(out_reg, N_OUT);
		lr = lr_reg;
		d = it.data_value;
		new_results.delete();
		case (it.req_type)
			REQ_LOAD_W: weights[it.row_index*N_IN + it.col_index] = it.data_value;
			REQ_LOAD_B: biases[it.row_index] = it.data_value;
			REQ_FWD: begin
				if (it.col_index >= ni) return 0;
				kept_x[it.col_index] = it.data_value;
				kept_ok[it.col_index] = 1;
				for (int i = 0; i < no; i++) begin
					p = fshift(d * longint'(weights[i*N_IN + it.col_index]), FRAC);
					if (it.col_index == 0) begin
						sums[i] = sat32(longint'(biases[i]) + p);
						sum_ok[i] = 1;
					end else
						sums[i] = sat32(longint'(sums[i]) + p);
				end
				if (it.col_index == ni - 1)
					for (int i = 0; i < no; i++) begin
						r.result_kind = RK_FWD;
						r.result_index = 6'(i);
						r.result_value = sums[i];
						r.is_last = (i == no - 1);
						new_results.push_back(r);
					end
			end
			default: begin
				if (it.row_index >= no) return 0;
				if (it.row_index == 0) begin
					for (int j = 0; j < N_IN; j++) grads[j] = '0;
					grad_ok = 1;
				end
				for (int j = 0; j < ni; j++) begin
					w = weights[it.row_index*N_IN + j];
					p = fshift(longint'(w) * d, FRAC);
					gw = sat32(fshift(longint'(kept_x[j]) * d, FRAC));
					grads[j] = sat32(longint'(grads[j]) + p);
					weights[it.row_index*N_IN + j] =
						sat32(longint'(w) - fshift(lr * longint'(gw), LR_BITS));
				end
				biases[it.row_index] =
					sat32(longint'(biases[it.row_index]) - fshift(lr * d, LR_BITS));
				if (it.row_index == no - 1)
					for (int j = 0; j < ni; j++) begin
						r.result_kind = RK_GRAD;
						r.result_index = 6'(j);
						r.result_value = grads[j];
						r.is_last = (j == ni - 1);
						new_results.push_back(r);
					end
			end
		endcase
		return 1;
	endfunction

	// offer one item in bursts with gaps; returns once it is taken
	task automatic send_item(req_t it, output bit useful);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
			gap = $urandom_range(1, 8);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.req_type <= it.req_type;
		req_ch.row_index <= it.row_index;
		req_ch.col_index <= it.col_index;
		req_ch.data_value <= it.data_value;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		useful = layer_predict(it);
		foreach (new_results[k]) layer_results.push_back(new_results[k]);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		while (layer_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		case (idx)
			CFG_IN_COUNT: in_reg = val[6:0];
			CFG_OUT_COUNT: out_reg = val[6:0];
			CFG_LR: lr_reg = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_layer(int ni, int no, int lr);
		drain();
		cfg_write(CFG_IN_COUNT, 16'(ni));
		cfg_write(CFG_OUT_COUNT, 16'(no));
		cfg_write(CFG_LR, 16'(lr));
	endtask

	function automatic logic signed [31:0] rand_data();
		if ($urandom_range(0, 9) < 2) return $urandom;
		return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
	endfunction

	function automatic req_t mk(int t, int row, int col, logic signed [31:0] d);
		req_t it;
		it.req_type = 2'(t);
		it.row_index = 6'(row);
		it.col_index = 6'(col);
		it.data_value = d;
		return it;
	endfunction

	task automatic add_row(logic [1:0] t, int row, int col, logic signed [31:0] d,
		bit known = 0, rsp_t first = '0);
		dir_row_t e;
		e.item = mk(t, row, col, d);
		e.known = known;
		e.first = first;
		script.push_back(e);
	endtask

	task automatic fwd_stream();
		bit u;
		for (int c = 0; c < eff(in_reg, N_IN); c++)
			send_item(mk(REQ_FWD, 0, c, rand_data()), u);
	endtask

	// backward stream; saves a full input vector first where one is missing
	task automatic bwd_stream();
		bit u;
		if (reads_unwritten(mk(REQ_BWD, 0, 0, 0))) fwd_stream();
		for (int r = 0; r < eff(out_reg, N_OUT); r++)
			send_item(mk(REQ_BWD, r, 0, rand_data()), u);
	endtask

	// first and last forward element only
	task automatic ends_fwd();
		bit u;
		send_item(mk(REQ_FWD, 0, 0, rand_data()), u);
		if (eff(in_reg, N_IN) > 1)
			send_item(mk(REQ_FWD, 0, eff(in_reg, N_IN) - 1, rand_data()), u);
	endtask

	// first and last backward element only, after a full input vector where one is missing
	task automatic ends_bwd();
		bit u;
		if (reads_unwritten(mk(REQ_BWD, 0, 0, 0))) fwd_stream();
		send_item(mk(REQ_BWD, 0, 0, rand_data()), u);
		if (eff(out_reg, N_OUT) > 1)
			send_item(mk(REQ_BWD, eff(out_reg, N_OUT) - 1, 0, rand_data()), u);
	endtask

	// random mix of streams, loads and stray items for one layer setting
	task automatic random_phase(int want);
		int done;
		int pick;
		bit u;
		req_t it;
		done = 0;
		while (done < want) begin
			pick = $urandom_range(0, 19);
			if (pick < 8) begin
				fwd_stream();
				done += eff(in_reg, N_IN);
			end else if (pick < 13) begin
				bwd_stream();
				done += eff(out_reg, N_OUT);
			end else begin
				if (pick < 16)
					it = mk($urandom_range(0, 1), $urandom_range(0, eff(out_reg, N_OUT) - 1),
						$urandom_range(0, eff(in_reg, N_IN) - 1), rand_data());
				else
					it = mk($urandom_range(0, 3), $urandom_range(0, 63),
						$urandom_range(0, 63), $urandom);
				if (reads_unwritten(it)) it = mk(REQ_FWD, 0, 0, it.data_value);
				send_item(it, u);
				if (u) done++;
			end
		end
	endtask

	// output side: check each result, stall on a changing pattern
	always @(posedge clk) begin : rx_side
		static int mode = 0;
		static int mode_left = 0;
		static int hold_left = 0;
		static int hold_seen = 0;
		rsp_t want;
		bit go;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (layer_results.size() == 0) begin
				$error("result with nothing expected: kind %0d index %0d value %0d",
					rsp_ch.result_kind, rsp_ch.result_index, rsp_ch.result_value);
				fails++;
			end else begin
				want = layer_results.pop_front();
				if (rsp_ch.result_kind !== want.result_kind) begin
					$error("result_kind expected %0d got %0d", want.result_kind,
						rsp_ch.result_kind);
					fails++;
				end
				if (rsp_ch.result_index !== want.result_index) begin
					$error("result_index expected %0d got %0d", want.result_index,
						rsp_ch.result_index);
					fails++;
				end
				if (rsp_ch.result_value !== want.result_value) begin
					$error("result_value expected %0d got %0d", want.result_value,
						rsp_ch.result_value);
					fails++;
				end
				if (rsp_ch.is_last !== want.is_last) begin
					$error("is_last expected %0d got %0d", want.is_last, rsp_ch.is_last);
					fails++;
				end
			end
		end
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD;
		end
		if (mode_left == 0) begin
			mode = $urandom_range(0, 2);
			mode_left = $urandom_range(50, 300);
		end
		mode_left--;
		case (mode)
			0: go = 1'b1;
			1: go = ($urandom_range(0, 3) != 0);
			default: go = ($urandom_range(0, 9) < 3);
		endcase
		if (hold_left > 0) begin
			hold_left--;
			go = 1'b0;
		end
		rsp_ch.ready <= go;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		bit u;
		fails = 0;
		cycles = 0;
		hold_req = 0;
		burst_left = 0;
		foreach (weights[k]) weights[k] = '0;
		foreach (biases[k]) biases[k] = '0;
		foreach (kept_x[k]) begin
			kept_x[k] = '0;
			kept_ok[k] = 0;
			grads[k] = '0;
		end
		foreach (sums[k]) begin
			sums[k] = '0;
			sum_ok[k] = 0;
		end
		grad_ok = 0;
		in_reg = 2;
		out_reg = 4;
		lr_reg = 655;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_LOAD_W;
		req_ch.row_index <= '0;
		req_ch.col_index <= '0;
		req_ch.data_value <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_IN_COUNT;
		cfg_ch.data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset sizes: 2 inputs, 4 outputs
		add_row(REQ_FWD, 0, 0, 32'sh00010000);
		add_row(REQ_FWD, 0, 1, 32'sh00010000, 1, '{RK_FWD, 6'd0, 32'sd0, 1'b0});
		add_row(REQ_LOAD_W, 0, 0, 32'sh7fffffff);
		add_row(REQ_LOAD_W, 63, 63, 32'sh80000000);
		add_row(REQ_LOAD_W, 3, 1, -32'sh00020000);
		add_row(REQ_LOAD_B, 0, 0, 32'sh7fffffff);
		add_row(REQ_LOAD_B, 63, 0, 32'sh80000000);
		add_row(REQ_LOAD_B, 2, 0, -32'sh00008000);
		add_row(REQ_FWD, 0, 0, 32'sh7fffffff);
		add_row(REQ_FWD, 0, 1, 32'sh80000000, 1, '{RK_FWD, 6'd0, 32'sh7fffffff, 1'b0});
		// index beyond the active sizes is ignored
		add_row(REQ_FWD, 0, 2, 32'sh00010000);
		add_row(REQ_FWD, 0, 63, 32'sh00010000);
		add_row(REQ_BWD, 4, 0, 32'sh00010000);
		add_row(REQ_BWD, 63, 63, 32'sh00010000);
		add_row(REQ_BWD, 0, 0, 32'sh00010000);
		add_row(REQ_BWD, 1, 0, 32'sh7fffffff);
		add_row(REQ_BWD, 2, 0, -32'sh00000001);
		add_row(REQ_BWD, 3, 0, 32'sh80000000);
		// out of order: element 1 before element 0 emits at element 1
		add_row(REQ_FWD, 0, 0, 32'sh00030000);
		add_row(REQ_FWD, 0, 1, -32'sh00010000);
		add_row(REQ_FWD, 0, 0, 32'sh00001000);
		add_row(REQ_BWD, 0, 0, -32'sh00010000);
		add_row(REQ_BWD, 3, 0, 32'sh00004000);
		add_row(REQ_BWD, 2, 0, 32'sh00020000);
		foreach (script[k]) begin
			send_item(script[k].item, u);
			if (script[k].known && (new_results.size() == 0
				|| new_results[0] !== script[k].first)) begin
				$error("row %0d first result expected %p got %p", k, script[k].first,
					new_results.size() ? new_results[0] : '0);
				fails++;
			end
		end

		// extremes of the registers; the spare index must change nothing
		set_layer(1, 1, 0);
		cfg_write(CFG_SPARE, 16'hffff);
		random_phase(4);
		set_layer(0, 0, 65535);
		random_phase(4);
		// widest input vector: first and last element
		set_layer(127, 0, 1);
		ends_fwd();
		// widest output vector, then first and last gradient element
		set_layer(0, 100, 40000);
		fwd_stream();
		ends_bwd();

		// long output stall while items keep coming
		set_layer(2, 8, 3000);
		hold_req = 1;
		repeat (3) fwd_stream();
		bwd_stream();

		// random settings, mostly small layers
		repeat (4) begin
			set_layer($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(0, 65535));
			random_phase(10);
		end

		drain();
		if (fails == 0 && layer_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
